// ===== hw/rtl/mpid_pkg.sv =====
// shared types and constants for the multichannel pid controller
package mpid_pkg;

    localparam int CHANNELS       = 3;
    localparam int GAIN_FRAC_BITS = 12;

    localparam int GAIN_W   = 20;
    localparam int GWORD_W  = 3 * GAIN_W;
    localparam int DATA_W   = 16;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int CH_W     = 2;
    localparam int ACC_W    = 48;
    localparam int ERR_W    = DATA_W + 1;
    localparam int PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int SUM_W    = ACC_W + 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GWORD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AUTO_MODE      = 3'd0,
        REG_REVERSE_ACTION = 3'd1,
        REG_SAMPLE_PERIOD  = 3'd2,
        REG_ACTIVE_CH      = 3'd3,
        REG_GAIN_WORD_0    = 3'd4,
        REG_GAIN_WORD_1    = 3'd5,
        REG_GAIN_WORD_2    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_COMPUTED = 2'd0,
        ST_NOT_DUE  = 2'd1,
        ST_MANUAL   = 2'd2
    } pid_status_t;

    localparam logic signed [DATA_W-1:0] DRIVE_MANUAL  = 16'sd999;
    localparam logic [PERIOD_W-1:0]      PERIOD_RESET  = 16'd10;
    localparam logic [CH_W-1:0]          ACTIVE_RESET  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measurement;
        logic [TIME_W-1:0]        now_ms;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic [CH_W-1:0]          channel;
        pid_status_t              status;
        logic                     saturated;
    } pid_out_t;

endpackage

// ===== hw/rtl/multichannel_pid_controller_core.sv =====
// top level of the multichannel pid controller
//
// input channel in_valid/in_ready/in_data carries setpoint, measurement and
// the millisecond time for the channel the round-robin pointer names; each
// input beat gives exactly one output beat on out_valid/out_ready/out_data
// with the drive value, the channel used, a status code and a clip flag.
// an input beat lands in an input register, then combinational logic (three
// 21x17 multiplies, integrator add and clip, truncation and 16-bit clip)
// fills the output register: out_valid rises when the beat moves from the
// input register into the output register, and one beat per cycle is
// sustained while out_ready is high.
// while the receiver stalls, the output register holds its beat and the input
// register can still take one more beat; after that in_ready drops.
// the user must write registers via cfg_we/cfg_addr/cfg_wdata only while idle;
// the block does not enforce it. turning auto mode on clears integrators,
// last measurements and times. reset puts manual mode, period 10, three
// channels, zero gains and zero state, with both pipeline registers empty.
module multichannel_pid_controller_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mpid_pkg::pid_in_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mpid_pkg::pid_out_t                out_data,
    input  logic                              cfg_we,
    input  logic [mpid_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mpid_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mpid_pkg::*;

    localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0] DRV_MAX  = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] DRV_MIN  = -SUM_W'(32768);
    localparam logic [CH_W:0]           CH_LIMIT = (CH_W + 1)'(CHANNELS);

    logic                     auto_reg;
    logic                     reverse_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic [CH_W-1:0]          active_reg;
    logic [GWORD_W-1:0]       gain_reg [CHANNELS];

    logic signed [ACC_W-1:0]  integ_reg [CHANNELS];
    logic signed [DATA_W-1:0] last_pv_reg [CHANNELS];
    logic [TIME_W-1:0]        last_time_reg [CHANNELS];
    logic [CH_W-1:0]          ptr_reg;

    logic                     in_vld_reg;
    pid_in_t                  in_data_reg;
    logic                     out_vld_reg;
    pid_out_t                 out_data_reg;

    logic                     adv;
    logic                     clear_stores;
    logic [CH_W-1:0]          n_act;
    logic [CH_W-1:0]          ch;
    logic [CH_IDX_W-1:0]      ch_idx;
    logic [CH_W:0]            ch_inc;
    logic [CH_W-1:0]          ptr_next;
    logic                     due;
    logic                     do_calc;
    logic [GAIN_W-1:0]        kp_u, ki_u, kd_u;
    logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
    logic signed [ERR_W-1:0]  err, dpv;
    logic signed [PROD_W-1:0] p_kp, p_ki, p_kd;
    logic signed [ACC_W:0]    integ_sum;
    logic signed [ACC_W-1:0]  integ_next;
    logic signed [SUM_W-1:0]  sum, q;
    pid_out_t                 res;

    assign adv          = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready     = !in_vld_reg || adv;
    assign out_valid    = out_vld_reg;
    assign out_data     = out_data_reg;
    assign clear_stores = cfg_we && (cfg_addr == REG_AUTO_MODE) && cfg_wdata[0] && !auto_reg;

    always_comb
    begin
        if (active_reg == '0)
            n_act = CH_W'(1);
        else if ({1'b0, active_reg} > CH_LIMIT)
            n_act = CH_W'(CHANNELS);
        else
            n_act = active_reg;
        ch       = (ptr_reg >= n_act) ? '0 : ptr_reg;
        ch_idx   = ch[CH_IDX_W-1:0];
        ch_inc   = {1'b0, ch} + (CH_W + 1)'(1);
        ptr_next = (ch_inc >= {1'b0, n_act}) ? '0 : ch_inc[CH_W-1:0];

        due     = (in_data_reg.now_ms - last_time_reg[ch_idx]) >= TIME_W'(period_reg);
        do_calc = auto_reg && due;

        kp_u = gain_reg[ch_idx][GAIN_W-1:0];
        ki_u = gain_reg[ch_idx][2*GAIN_W-1:GAIN_W];
        kd_u = gain_reg[ch_idx][3*GAIN_W-1:2*GAIN_W];
        kp_s = reverse_reg ? -$signed({1'b0, kp_u}) : $signed({1'b0, kp_u});
        ki_s = reverse_reg ? -$signed({1'b0, ki_u}) : $signed({1'b0, ki_u});
        kd_s = reverse_reg ? -$signed({1'b0, kd_u}) : $signed({1'b0, kd_u});

        err  = ERR_W'(in_data_reg.setpoint) - ERR_W'(in_data_reg.measurement);
        dpv  = ERR_W'(in_data_reg.measurement) - ERR_W'(last_pv_reg[ch_idx]);
        p_kp = PROD_W'(kp_s) * PROD_W'(err);
        p_ki = PROD_W'(ki_s) * PROD_W'(err);
        p_kd = PROD_W'(kd_s) * PROD_W'(dpv);

        integ_sum = (ACC_W + 1)'(integ_reg[ch_idx]) + (ACC_W + 1)'(p_ki);
        if (integ_sum[ACC_W] != integ_sum[ACC_W-1])
            integ_next = integ_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
        else
            integ_next = integ_sum[ACC_W-1:0];

        sum = SUM_W'(p_kp) + SUM_W'(integ_next) - SUM_W'(p_kd);
        q   = $signed(sum + (sum[SUM_W-1] ? RND_BIAS : '0)) >>> GAIN_FRAC_BITS;

        res.channel   = ch;
        res.saturated = 1'b0;
        if (!auto_reg)
        begin
            res.drive  = DRIVE_MANUAL;
            res.status = ST_MANUAL;
        end
        else if (!due)
        begin
            res.drive  = '0;
            res.status = ST_NOT_DUE;
        end
        else
        begin
            res.status = ST_COMPUTED;
            if (q > DRV_MAX)
            begin
                res.drive     = DRV_MAX[DATA_W-1:0];
                res.saturated = 1'b1;
            end
            else if (q < DRV_MIN)
            begin
                res.drive     = DRV_MIN[DATA_W-1:0];
                res.saturated = 1'b1;
            end
            else
                res.drive = q[DATA_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg    <= 1'b0;
            reverse_reg <= 1'b0;
            period_reg  <= PERIOD_RESET;
            active_reg  <= ACTIVE_RESET;
            for (int i = 0; i < CHANNELS; i++)
                gain_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_AUTO_MODE:      auto_reg    <= cfg_wdata[0];
                REG_REVERSE_ACTION: reverse_reg <= cfg_wdata[0];
                REG_SAMPLE_PERIOD:  period_reg  <= cfg_wdata[PERIOD_W-1:0];
                REG_ACTIVE_CH:      active_reg  <= cfg_wdata[CH_W-1:0];
                default:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        if (cfg_addr == REG_GAIN_WORD_0 + CFG_ADDR_W'(i))
                            gain_reg[i] <= cfg_wdata;
                end
            endcase
        end
    end

    // per-channel controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                integ_reg[i]     <= '0;
                last_pv_reg[i]   <= '0;
                last_time_reg[i] <= '0;
            end
        end
        else if (clear_stores)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                integ_reg[i]     <= '0;
                last_pv_reg[i]   <= '0;
                last_time_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            if (do_calc)
            begin
                ptr_reg                <= ptr_next;
                integ_reg[ch_idx]      <= integ_next;
                last_pv_reg[ch_idx]    <= in_data_reg.measurement;
                last_time_reg[ch_idx]  <= in_data_reg.now_ms;
            end
            else
                ptr_reg <= ch;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (adv)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (adv)
            out_data_reg <= res;
    end

    a_sat_only_computed: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.status != ST_COMPUTED |-> !out_data_reg.saturated)
        else $error("clip flag set on a beat that was not computed");

    a_manual_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.status == ST_MANUAL |-> out_data_reg.drive == DRIVE_MANUAL)
        else $error("manual beat with wrong drive");

    a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        adv && do_calc && !clear_stores |=> ptr_reg == $past(ptr_next))
        else $error("pointer did not advance after a computed beat");

    a_out_channel: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg && out_data_reg.channel == $past(ch))
        else $error("output beat carries wrong channel");

endmodule
